@@ sv/uswk_pkg.sv @@
// Shared types, register map and time helpers for the USB suspend/wake supervisor.
package uswk_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_t;

  typedef enum logic [2:0] {
    REG_SOF_WINDOW     = 3'd0,
    REG_DETACH_PULSE   = 3'd1,
    REG_REENUM_GRACE   = 3'd2,
    REG_PULSE_RETRY    = 3'd3,
    REG_WAKE_FALLBACK  = 3'd4,
    REG_UNUSABLE_LIMIT = 3'd5
  } reg_idx_t;

  localparam cfg_t SOF_WINDOW_RST     = cfg_t'(250);
  localparam cfg_t DETACH_PULSE_RST   = cfg_t'(300);
  localparam cfg_t REENUM_GRACE_RST   = cfg_t'(1000);
  localparam cfg_t PULSE_RETRY_RST    = cfg_t'(2500);
  localparam cfg_t WAKE_FALLBACK_RST  = cfg_t'(1000);
  localparam cfg_t UNUSABLE_LIMIT_RST = cfg_t'(10000);

  // 0 marks an unset stamp, so time 0 is kept as 1
  function automatic time_t nz(time_t t);
    return (t == '0) ? time_t'(1) : t;
  endfunction

  // wrapped elapsed time since stamp, compared against a limit
  function automatic logic since_ge(time_t now, time_t stamp, cfg_t lim);
    time_t d;
    d = now - stamp;
    return d >= time_t'(lim);
  endfunction

endpackage

@@ sv/usb_suspend_wake_supervisor_core.sv @@
// Top level of the USB suspend/wake supervisor: input stage, step logic, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  item     | item_valid / item_ready   | action, now_ms, configured, sof_seen, bus_suspend
//  result   | result_valid/result_ready | disconnect_now, reconnect_now, clear_sof,
//           |                           | resume_signal, wake_accepted, host_asleep
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One request per cycle sustained while the result is not stalled.
// The step logic sits between the input stage and the result register and updates
// the stamps as the request moves into the result register.
// rst (synchronous) clears all stamps and flags and loads register defaults.
// A stalled result holds the input stage, which then holds item_ready low.
module usb_suspend_wake_supervisor_core
  import uswk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 action,
  input  logic [31:0]          now_ms,
  input  logic                 configured,
  input  logic                 sof_seen,
  input  logic                 bus_suspend,

  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 disconnect_now,
  output logic                 reconnect_now,
  output logic                 clear_sof,
  output logic                 resume_signal,
  output logic                 wake_accepted,
  output logic                 host_asleep,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t sof_window, detach_pulse, reenum_grace, pulse_retry, wake_fallback, unusable_limit;

  time_t alive, reattach, sof_stamp, resumed, wake, pulse;
  logic  sof_fresh, ever_cfg, saw_sleep;

  time_t alive_next, reattach_next, sof_stamp_next, resumed_next, wake_next, pulse_next;
  logic  sof_fresh_next, ever_cfg_next, saw_sleep_next;

  logic  s1_valid;
  logic  s1_action, s1_cfg, s1_sof, s1_bsus;
  time_t s1_now;
  logic  adv;

  logic disc, reconn, clr, resume, acc, asleep_old, asleep_new;

  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sof_window     <= SOF_WINDOW_RST;
      detach_pulse   <= DETACH_PULSE_RST;
      reenum_grace   <= REENUM_GRACE_RST;
      pulse_retry    <= PULSE_RETRY_RST;
      wake_fallback  <= WAKE_FALLBACK_RST;
      unusable_limit <= UNUSABLE_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SOF_WINDOW:     sof_window     <= pwdata[CFG_BITS-1:0];
        REG_DETACH_PULSE:   detach_pulse   <= pwdata[CFG_BITS-1:0];
        REG_REENUM_GRACE:   reenum_grace   <= pwdata[CFG_BITS-1:0];
        REG_PULSE_RETRY:    pulse_retry    <= pwdata[CFG_BITS-1:0];
        REG_WAKE_FALLBACK:  wake_fallback  <= pwdata[CFG_BITS-1:0];
        REG_UNUSABLE_LIMIT: unusable_limit <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOF_WINDOW:     prdata = DATA_BITS'(sof_window);
      REG_DETACH_PULSE:   prdata = DATA_BITS'(detach_pulse);
      REG_REENUM_GRACE:   prdata = DATA_BITS'(reenum_grace);
      REG_PULSE_RETRY:    prdata = DATA_BITS'(pulse_retry);
      REG_WAKE_FALLBACK:  prdata = DATA_BITS'(wake_fallback);
      REG_UNUSABLE_LIMIT: prdata = DATA_BITS'(unusable_limit);
      default:            prdata = '0;
    endcase
  end

  // input stage
  assign adv        = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s1_action <= action;
      s1_now    <= time_t'(now_ms);
      s1_cfg    <= configured;
      s1_sof    <= sof_seen;
      s1_bsus   <= bus_suspend;
    end
  end

  // step logic
  always_comb begin
    alive_next     = alive;
    reattach_next  = reattach;
    sof_stamp_next = sof_stamp;
    resumed_next   = resumed;
    wake_next      = wake;
    pulse_next     = pulse;
    sof_fresh_next = sof_fresh;
    ever_cfg_next  = ever_cfg;
    saw_sleep_next = saw_sleep;
    disc   = 1'b0;
    reconn = 1'b0;
    clr    = 1'b0;
    resume = 1'b0;
    acc    = 1'b0;

    asleep_old = (reattach == '0) &&
                 ((ever_cfg && (!sof_fresh || s1_bsus)) ||
                  (alive != '0 && since_ge(s1_now, alive, unusable_limit)));

    if (!s1_action) begin
      if (alive == '0) alive_next = nz(s1_now);
      if (reattach != '0) begin
        if (since_ge(s1_now, reattach, detach_pulse)) begin
          reconn        = 1'b1;
          reattach_next = '0;
        end
      end else begin
        if (sof_stamp == '0 || since_ge(s1_now, sof_stamp, sof_window)) begin
          sof_stamp_next = nz(s1_now);
          sof_fresh_next = s1_sof;
          clr            = 1'b1;
        end
        if (s1_cfg && sof_fresh_next) begin
          ever_cfg_next  = 1'b1;
          alive_next     = nz(s1_now);
          saw_sleep_next = 1'b0;
          resumed_next   = '0;
          wake_next      = '0;
          pulse_next     = '0;
        end else if (ever_cfg ||
                     (alive_next != '0 && since_ge(s1_now, alive_next, unusable_limit))) begin
          if (sof_fresh_next) begin
            if (saw_sleep) begin
              if (resumed == '0) begin
                resumed_next = nz(s1_now);
              end else if (since_ge(s1_now, resumed, reenum_grace) &&
                           (pulse == '0 || since_ge(s1_now, pulse, pulse_retry))) begin
                pulse_next    = nz(s1_now);
                disc          = 1'b1;
                reattach_next = nz(s1_now);
                wake_next     = '0;
              end
            end
          end else begin
            saw_sleep_next = 1'b1;
            resumed_next   = '0;
            if (wake != '0 && since_ge(s1_now, wake, wake_fallback)) begin
              disc          = 1'b1;
              reattach_next = nz(s1_now);
              wake_next     = '0;
            end
          end
        end
      end
    end else if (asleep_old) begin
      acc = 1'b1;
      if (s1_bsus) begin
        resume = 1'b1;
        if (wake == '0) wake_next = nz(s1_now);
      end else begin
        disc          = 1'b1;
        reattach_next = nz(s1_now);
        wake_next     = '0;
      end
    end

    asleep_new = (reattach_next == '0) &&
                 ((ever_cfg_next && (!sof_fresh_next || s1_bsus)) ||
                  (alive_next != '0 && since_ge(s1_now, alive_next, unusable_limit)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive     <= '0;
      reattach  <= '0;
      sof_stamp <= '0;
      resumed   <= '0;
      wake      <= '0;
      pulse     <= '0;
      sof_fresh <= 1'b0;
      ever_cfg  <= 1'b0;
      saw_sleep <= 1'b0;
    end else if (adv) begin
      alive     <= alive_next;
      reattach  <= reattach_next;
      sof_stamp <= sof_stamp_next;
      resumed   <= resumed_next;
      wake      <= wake_next;
      pulse     <= pulse_next;
      sof_fresh <= sof_fresh_next;
      ever_cfg  <= ever_cfg_next;
      saw_sleep <= saw_sleep_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= adv || (result_valid && !result_ready);
    end
    if (adv) begin
      disconnect_now <= disc;
      reconnect_now  <= reconn;
      clear_sof      <= clr;
      resume_signal  <= resume;
      wake_accepted  <= acc;
      host_asleep    <= asleep_new;
    end
  end

endmodule
